[rtl/core/hsv_pkg.sv]
package hsv_pkg;

  // Field widths
  localparam int HUE_W = 16;
  localparam int SAT_W = 9;
  localparam int CH_W  = 8;
  localparam int CH_MAX = 255;

  // Hue fixed point: degrees with HUE_FRAC_BITS fraction bits
  localparam int HUE_FRAC_BITS = 6;
  localparam int HUE_INT_W     = HUE_W - HUE_FRAC_BITS;
  localparam int SECTOR_SIZE   = 60 << HUE_FRAC_BITS;
  localparam int FULL_TURN     = 360 << HUE_FRAC_BITS;

  // Sector estimate: floor(h / 60) via reciprocal, low by at most one
  localparam int RECIP_SHIFT = HUE_INT_W + 6;
  localparam int RECIP       = (1 << RECIP_SHIFT) / 60;
  localparam int RPROD_W     = HUE_INT_W + RECIP_SHIFT;
  localparam int SECT_W      = $clog2((1 << HUE_INT_W) / 60 + 1);

  // Sector offset and its complement, both in 0..SECTOR_SIZE
  localparam int X_W = $clog2(SECTOR_SIZE + 1);

  // Level numerator: 256*D - S*x
  localparam int FULL_LEVEL = 256 * SECTOR_SIZE;
  localparam int SX_W       = SAT_W + X_W;
  localparam int N_W        = $clog2(FULL_LEVEL + 1);

  // Channel = floor(V*n*255 / (65536*D)) = (V*n*17) >> (18 + frac bits)
  localparam int PROD_W    = SAT_W + N_W + 5;
  localparam int OUT_SHIFT = 18 + HUE_FRAC_BITS;
  localparam int Q_W       = PROD_W - OUT_SHIFT;

  // Level lanes
  localparam int LANES = 4;
  localparam int L_TOP = 0;   // V
  localparam int L_AA  = 1;   // V(1-S)
  localparam int L_BB  = 2;   // V(1-S*f)
  localparam int L_CC  = 3;   // V(1-S(1-f))

  // Hue sectors
  localparam int SEC_RED_YEL = 0;
  localparam int SEC_YEL_GRN = 1;
  localparam int SEC_GRN_CYN = 2;
  localparam int SEC_CYN_BLU = 3;
  localparam int SEC_BLU_MAG = 4;
  localparam int SEC_MAG_RED = 5;

  typedef struct packed {
    logic [SECT_W-1:0] sector;
    logic [X_W-1:0]    frac;
    logic [X_W-1:0]    frac_c;
    logic [SAT_W-1:0]  sat;
    logic [SAT_W-1:0]  bri;
  } sect_t;

  typedef struct packed {
    logic [SECT_W-1:0]             sector;
    logic                          grey;
    logic [LANES-1:0][PROD_W-1:0]  prod;
  } lvl_t;

endpackage

[rtl/core/hsv_in_if.sv]
interface hsv_in_if;
  logic                          valid;
  logic                          ready;
  logic [hsv_pkg::HUE_W-1:0]     hue_in;
  logic [hsv_pkg::SAT_W-1:0]     saturation_in;
  logic [hsv_pkg::SAT_W-1:0]     brightness_in;

  modport source (output valid, output hue_in, output saturation_in,
                  output brightness_in, input ready);
  modport sink   (input valid, input hue_in, input saturation_in,
                  input brightness_in, output ready);
endinterface

[rtl/core/hsv_out_if.sv]
interface hsv_out_if;
  logic                       valid;
  logic                       ready;
  logic [hsv_pkg::CH_W-1:0]   red_out;
  logic [hsv_pkg::CH_W-1:0]   green_out;
  logic [hsv_pkg::CH_W-1:0]   blue_out;

  modport source (output valid, output red_out, output green_out,
                  output blue_out, input ready);
  modport sink   (input valid, input red_out, input green_out,
                  input blue_out, output ready);
endinterface

[rtl/core/hsv_to_rgb_converter.sv]
// Channel  Direction  Payload                                      Handshake
// in_ch    sink       hue_in[15:0] saturation_in[8:0] brightness_in[8:0]  valid/ready
// out_ch   source     red_out[7:0] green_out[7:0] blue_out[7:0]    valid/ready
//
// One pixel per clock sustained while out_ch.ready holds; five register stages
// (sector divide: 2, level lanes: 2, scale and select: 1). A result is registered
// in each stage in turn before it is valid at the outputs.
// Synchronous active-low reset empties every stage; payload is not reset.
// Stalls from out_ch ripple back stage by stage; empty stages keep filling,
// so in_ch.ready drops only when all five stages hold data.
module hsv_to_rgb_converter (
  input  logic      clk,
  input  logic      rst_n,
  hsv_in_if.sink    in_ch,
  hsv_out_if.source out_ch
);

  logic                        sec_valid;
  logic                        sec_ready;
  hsv_pkg::sect_t              sec_data;
  logic                        lvl_valid;
  logic                        lvl_ready;
  hsv_pkg::lvl_t               lvl_data;

  logic                        out_valid_r;
  logic [hsv_pkg::CH_W-1:0]    red_r;
  logic [hsv_pkg::CH_W-1:0]    green_r;
  logic [hsv_pkg::CH_W-1:0]    blue_r;

  logic [hsv_pkg::LANES-1:0][hsv_pkg::Q_W-1:0]  q;
  logic [hsv_pkg::LANES-1:0][hsv_pkg::CH_W-1:0] ch;
  logic [hsv_pkg::CH_W-1:0]    red_nxt;
  logic [hsv_pkg::CH_W-1:0]    green_nxt;
  logic [hsv_pkg::CH_W-1:0]    blue_nxt;

  hsv_sector u_sector (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_valid (sec_valid),
    .out_ready (sec_ready),
    .out_data  (sec_data)
  );

  hsv_level u_level (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sec_valid),
    .in_ready  (sec_ready),
    .in_data   (sec_data),
    .out_valid (lvl_valid),
    .out_ready (lvl_ready),
    .out_data  (lvl_data)
  );

  assign lvl_ready = !out_valid_r || out_ch.ready;

  // Stage 5: scale down, saturate, route levels by sector (grey: V on all channels)
  always_comb begin
    for (int l = 0; l < hsv_pkg::LANES; l++) begin
      q[l] = lvl_data.prod[l][hsv_pkg::PROD_W-1:hsv_pkg::OUT_SHIFT];
      if (q[l] > hsv_pkg::Q_W'(hsv_pkg::CH_MAX)) begin
        ch[l] = hsv_pkg::CH_W'(hsv_pkg::CH_MAX);
      end else begin
        ch[l] = hsv_pkg::CH_W'(q[l]);
      end
    end
    red_nxt   = '0;
    green_nxt = '0;
    blue_nxt  = '0;
    if (lvl_data.grey) begin
      red_nxt   = ch[hsv_pkg::L_TOP];
      green_nxt = ch[hsv_pkg::L_TOP];
      blue_nxt  = ch[hsv_pkg::L_TOP];
    end else begin
      case (32'(lvl_data.sector))
        hsv_pkg::SEC_RED_YEL: begin
          red_nxt   = ch[hsv_pkg::L_TOP];
          green_nxt = ch[hsv_pkg::L_CC];
          blue_nxt  = ch[hsv_pkg::L_AA];
        end
        hsv_pkg::SEC_YEL_GRN: begin
          red_nxt   = ch[hsv_pkg::L_BB];
          green_nxt = ch[hsv_pkg::L_TOP];
          blue_nxt  = ch[hsv_pkg::L_AA];
        end
        hsv_pkg::SEC_GRN_CYN: begin
          red_nxt   = ch[hsv_pkg::L_AA];
          green_nxt = ch[hsv_pkg::L_TOP];
          blue_nxt  = ch[hsv_pkg::L_CC];
        end
        hsv_pkg::SEC_CYN_BLU: begin
          red_nxt   = ch[hsv_pkg::L_AA];
          green_nxt = ch[hsv_pkg::L_BB];
          blue_nxt  = ch[hsv_pkg::L_TOP];
        end
        hsv_pkg::SEC_BLU_MAG: begin
          red_nxt   = ch[hsv_pkg::L_CC];
          green_nxt = ch[hsv_pkg::L_AA];
          blue_nxt  = ch[hsv_pkg::L_TOP];
        end
        hsv_pkg::SEC_MAG_RED: begin
          red_nxt   = ch[hsv_pkg::L_TOP];
          green_nxt = ch[hsv_pkg::L_AA];
          blue_nxt  = ch[hsv_pkg::L_BB];
        end
        default: begin
          // hue past the full turn: black
          red_nxt   = '0;
          green_nxt = '0;
          blue_nxt  = '0;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (lvl_ready) begin
      out_valid_r <= lvl_valid;
    end
    if (lvl_ready && lvl_valid) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.red_out   = red_r;
  assign out_ch.green_out = green_r;
  assign out_ch.blue_out  = blue_r;

endmodule

[rtl/core/hsv_sector.sv]
// Two stages: hue wrap and sector estimate, then remainder and correction
module hsv_sector (
  input  logic           clk,
  input  logic           rst_n,
  hsv_in_if.sink         in_ch,
  output logic           out_valid,
  input  logic           out_ready,
  output hsv_pkg::sect_t out_data
);

  logic                              s1_valid_r;
  logic                              s1_ready;
  logic [hsv_pkg::HUE_W-1:0]         s1_hue_r;
  logic [hsv_pkg::SECT_W-1:0]        s1_q_r;
  logic [hsv_pkg::SAT_W-1:0]         s1_sat_r;
  logic [hsv_pkg::SAT_W-1:0]         s1_bri_r;

  logic                              s2_valid_r;
  logic                              s2_ready;
  hsv_pkg::sect_t                    s2_data_r;

  logic [hsv_pkg::HUE_W-1:0]         hue_wrap;
  logic [hsv_pkg::HUE_INT_W-1:0]     hue_int;
  logic [hsv_pkg::RPROD_W-1:0]       rprod;
  logic [hsv_pkg::SECT_W-1:0]        q_est;

  logic [hsv_pkg::HUE_W-1:0]         base;
  logic [hsv_pkg::HUE_W-1:0]         rem;
  logic                              rem_over;
  logic [hsv_pkg::HUE_W-1:0]         rem_fix;
  logic [hsv_pkg::SECT_W-1:0]        sector_nxt;
  logic [hsv_pkg::X_W-1:0]           frac_nxt;

  // Ready chain
  assign s2_ready    = !s2_valid_r || out_ready;
  assign s1_ready    = !s1_valid_r || s2_ready;
  assign in_ch.ready = s1_ready;

  // Stage 1: full turn wraps to zero, reciprocal multiply
  always_comb begin
    hue_wrap = (32'(in_ch.hue_in) == hsv_pkg::FULL_TURN) ? '0 : in_ch.hue_in;
    hue_int  = hsv_pkg::HUE_INT_W'(hue_wrap >> hsv_pkg::HUE_FRAC_BITS);
    rprod    = hsv_pkg::RPROD_W'(hue_int) * hsv_pkg::RPROD_W'(hsv_pkg::RECIP);
    q_est    = hsv_pkg::SECT_W'(rprod[hsv_pkg::RPROD_W-1:hsv_pkg::RECIP_SHIFT]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_ch.valid;
    end
    if (s1_ready && in_ch.valid) begin
      s1_hue_r <= hue_wrap;
      s1_q_r   <= q_est;
      s1_sat_r <= in_ch.saturation_in;
      s1_bri_r <= in_ch.brightness_in;
    end
  end

  // Stage 2: remainder, one correction step, sector offset complement
  always_comb begin
    base       = hsv_pkg::HUE_W'(32'(s1_q_r) * hsv_pkg::SECTOR_SIZE);
    rem        = s1_hue_r - base;
    rem_over   = (32'(rem) >= hsv_pkg::SECTOR_SIZE);
    rem_fix    = rem_over ? (rem - hsv_pkg::HUE_W'(hsv_pkg::SECTOR_SIZE)) : rem;
    sector_nxt = rem_over ? (s1_q_r + hsv_pkg::SECT_W'(1)) : s1_q_r;
    frac_nxt   = hsv_pkg::X_W'(rem_fix);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r;
    end
    if (s2_ready && s1_valid_r) begin
      s2_data_r.sector <= sector_nxt;
      s2_data_r.frac   <= frac_nxt;
      s2_data_r.frac_c <= hsv_pkg::X_W'(hsv_pkg::SECTOR_SIZE) - frac_nxt;
      s2_data_r.sat    <= s1_sat_r;
      s2_data_r.bri    <= s1_bri_r;
    end
  end

  assign out_valid = s2_valid_r;
  assign out_data  = s2_data_r;

endmodule

[rtl/core/hsv_level.sv]
// Two stages over four lanes: numerator 256*D - S*x, then V*n*17
module hsv_level (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  hsv_pkg::sect_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output hsv_pkg::lvl_t  out_data
);

  logic                                          s3_valid_r;
  logic                                          s3_ready;
  logic [hsv_pkg::SECT_W-1:0]                    s3_sector_r;
  logic                                          s3_grey_r;
  logic [hsv_pkg::SAT_W-1:0]                     s3_bri_r;
  logic [hsv_pkg::LANES-1:0][hsv_pkg::N_W-1:0]   s3_n_r;

  logic                                          s4_valid_r;
  logic                                          s4_ready;
  hsv_pkg::lvl_t                                 s4_data_r;

  logic [hsv_pkg::LANES-1:0][hsv_pkg::X_W-1:0]   x_sel;
  logic [hsv_pkg::LANES-1:0][hsv_pkg::SX_W-1:0]  sx;
  logic [hsv_pkg::LANES-1:0][hsv_pkg::N_W-1:0]   n_nxt;
  logic [hsv_pkg::LANES-1:0][hsv_pkg::PROD_W-1:0] vn;
  logic [hsv_pkg::LANES-1:0][hsv_pkg::PROD_W-1:0] prod_nxt;

  assign s4_ready = !s4_valid_r || out_ready;
  assign s3_ready = !s3_valid_r || s4_ready;
  assign in_ready = s3_ready;

  // Stage 3: blend offset per lane; negative numerators clamp to zero; grey when S is zero
  always_comb begin
    x_sel[hsv_pkg::L_TOP] = '0;
    x_sel[hsv_pkg::L_AA]  = hsv_pkg::X_W'(hsv_pkg::SECTOR_SIZE);
    x_sel[hsv_pkg::L_BB]  = in_data.frac;
    x_sel[hsv_pkg::L_CC]  = in_data.frac_c;
    for (int l = 0; l < hsv_pkg::LANES; l++) begin
      sx[l] = hsv_pkg::SX_W'(in_data.sat) * hsv_pkg::SX_W'(x_sel[l]);
      if (sx[l] < hsv_pkg::SX_W'(hsv_pkg::FULL_LEVEL)) begin
        n_nxt[l] = hsv_pkg::N_W'(hsv_pkg::SX_W'(hsv_pkg::FULL_LEVEL) - sx[l]);
      end else begin
        n_nxt[l] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (s3_ready) begin
      s3_valid_r <= in_valid;
    end
    if (s3_ready && in_valid) begin
      s3_sector_r <= in_data.sector;
      s3_grey_r   <= (in_data.sat == '0);
      s3_bri_r    <= in_data.bri;
      s3_n_r      <= n_nxt;
    end
  end

  // Stage 4: brightness times numerator, times 17 by shift and add
  always_comb begin
    for (int l = 0; l < hsv_pkg::LANES; l++) begin
      vn[l]       = hsv_pkg::PROD_W'(s3_bri_r) * hsv_pkg::PROD_W'(s3_n_r[l]);
      prod_nxt[l] = (vn[l] << 4) + vn[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (s4_ready) begin
      s4_valid_r <= s3_valid_r;
    end
    if (s4_ready && s3_valid_r) begin
      s4_data_r.sector <= s3_sector_r;
      s4_data_r.grey   <= s3_grey_r;
      s4_data_r.prod   <= prod_nxt;
    end
  end

  assign out_valid = s4_valid_r;
  assign out_data  = s4_data_r;

endmodule

[rtl/core/hsv_checker.sv]
module hsv_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [hsv_pkg::CH_W-1:0]   red_out,
  input logic [hsv_pkg::CH_W-1:0]   green_out,
  input logic [hsv_pkg::CH_W-1:0]   blue_out
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(red_out)
      && $stable(green_out) && $stable(blue_out))
    else $error("result changed while stalled");

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // Input backpressure only while the output holds a stalled result
  a_bp_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with room in the pipeline");

  // While the input stays stalled, the output result stays valid
  a_bp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready && $past(!out_ready) && $past(out_valid) && rst_n && $past(rst_n)
      && $past(!in_ready) |-> out_valid)
    else $error("output dropped during backpressure");

endmodule

bind hsv_to_rgb_converter hsv_checker u_hsv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .red_out   (out_ch.red_out),
  .green_out (out_ch.green_out),
  .blue_out  (out_ch.blue_out)
);

[verif/hsv_to_rgb_converter_tb.sv]
module hsv_to_rgb_converter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_PIXELS = 900;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 12;
  localparam int N_DIRECTED    = 22;

  typedef struct packed {
    logic [hsv_pkg::CH_W-1:0] red;
    logic [hsv_pkg::CH_W-1:0] green;
    logic [hsv_pkg::CH_W-1:0] blue;
  } rgb_t;

  // One directed pixel; known_rgb marks rows whose answer is typed in
  typedef struct {
    logic [hsv_pkg::HUE_W-1:0] hue;
    logic [hsv_pkg::SAT_W-1:0] sat;
    logic [hsv_pkg::SAT_W-1:0] bri;
    bit                        known_rgb;
    logic [hsv_pkg::CH_W-1:0]  red;
    logic [hsv_pkg::CH_W-1:0]  green;
    logic [hsv_pkg::CH_W-1:0]  blue;
  } pixel_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic sink_ready = 1'b0;

  hsv_in_if  in_bus ();
  hsv_out_if out_bus ();

  assign out_bus.ready = sink_ready;

  hsv_to_rgb_converter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  always #10 clk = ~clk;

  rgb_t expected_rgb [$];
  int   fail_count = 0;
  int   cycle_count = 0;
  bit   in_calm = 1'b0;
  bit   out_calm = 1'b0;

  // Primary colors, grey, black and the corner cases of the hue circle
  pixel_row_t pixel_rows [0:N_DIRECTED-1] = '{
    '{16'd0,     9'd0,   9'd0,   1'b1, 8'd0,   8'd0,   8'd0},
    '{16'd0,     9'd0,   9'd256, 1'b1, 8'd255, 8'd255, 8'd255},
    '{16'd12345, 9'd0,   9'd511, 1'b1, 8'd255, 8'd255, 8'd255},
    '{16'd0,     9'd0,   9'd1,   1'b1, 8'd0,   8'd0,   8'd0},
    '{16'd0,     9'd256, 9'd256, 1'b1, 8'd255, 8'd0,   8'd0},
    '{16'd3840,  9'd256, 9'd256, 1'b1, 8'd255, 8'd255, 8'd0},
    '{16'd7680,  9'd256, 9'd256, 1'b1, 8'd0,   8'd255, 8'd0},
    '{16'd11520, 9'd256, 9'd256, 1'b1, 8'd0,   8'd255, 8'd255},
    '{16'd15360, 9'd256, 9'd256, 1'b1, 8'd0,   8'd0,   8'd255},
    '{16'd19200, 9'd256, 9'd256, 1'b1, 8'd255, 8'd0,   8'd255},
    '{16'd23040, 9'd256, 9'd256, 1'b1, 8'd255, 8'd0,   8'd0},
    '{16'd23041, 9'd256, 9'd256, 1'b1, 8'd0,   8'd0,   8'd0},
    '{16'd65535, 9'd256, 9'd256, 1'b1, 8'd0,   8'd0,   8'd0},
    '{16'd65535, 9'd511, 9'd511, 1'b1, 8'd0,   8'd0,   8'd0},
    '{16'd17000, 9'd256, 9'd0,   1'b1, 8'd0,   8'd0,   8'd0},
    '{16'd23039, 9'd256, 9'd256, 1'b0, 8'd0,   8'd0,   8'd0},
    '{16'd1,     9'd256, 9'd256, 1'b0, 8'd0,   8'd0,   8'd0},
    '{16'd1920,  9'd128, 9'd200, 1'b0, 8'd0,   8'd0,   8'd0},
    '{16'd5000,  9'd511, 9'd256, 1'b0, 8'd0,   8'd0,   8'd0},
    '{16'd9000,  9'd300, 9'd511, 1'b0, 8'd0,   8'd0,   8'd0},
    '{16'd21000, 9'd1,   9'd256, 1'b0, 8'd0,   8'd0,   8'd0},
    '{16'd3839,  9'd511, 9'd511, 1'b0, 8'd0,   8'd0,   8'd0}
  };

  // floor(V * (256*D - S*x) * 255 / (65536*D)), clamped to 0..255
  function automatic logic [hsv_pkg::CH_W-1:0] scale_level(longint v, longint s, longint x);
    longint num;
    longint q;
    num = v * (256 * longint'(hsv_pkg::SECTOR_SIZE) - s * x);
    if (num <= 0) return '0;
    q = (num * hsv_pkg::CH_MAX) / (longint'(65536) * hsv_pkg::SECTOR_SIZE);
    if (q > hsv_pkg::CH_MAX) q = hsv_pkg::CH_MAX;
    return q[hsv_pkg::CH_W-1:0];
  endfunction

  function automatic rgb_t predict_rgb(logic [hsv_pkg::HUE_W-1:0] hue,
                                       logic [hsv_pkg::SAT_W-1:0] sat,
                                       logic [hsv_pkg::SAT_W-1:0] bri);
    longint h;
    longint s;
    longint v;
    longint d;
    longint sector;
    longint f;
    logic [hsv_pkg::CH_W-1:0] top, aa, bb, cc;
    rgb_t c;
    h = longint'(hue);
    s = longint'(sat);
    v = longint'(bri);
    d = longint'(hsv_pkg::SECTOR_SIZE);
    // grey: hue plays no part
    if (s == 0) begin
      top = scale_level(v, 0, 0);
      return '{top, top, top};
    end
    if (h == hsv_pkg::FULL_TURN) h = 0;
    sector = h / d;
    f      = h % d;
    top = scale_level(v, s, 0);
    aa  = scale_level(v, s, d);
    bb  = scale_level(v, s, f);
    cc  = scale_level(v, s, d - f);
    case (sector)
      hsv_pkg::SEC_RED_YEL: c = '{top, cc, aa};
      hsv_pkg::SEC_YEL_GRN: c = '{bb, top, aa};
      hsv_pkg::SEC_GRN_CYN: c = '{aa, top, cc};
      hsv_pkg::SEC_CYN_BLU: c = '{aa, bb, top};
      hsv_pkg::SEC_BLU_MAG: c = '{cc, aa, top};
      hsv_pkg::SEC_MAG_RED: c = '{top, aa, bb};
      default:              c = '0;
    endcase
    return c;
  endfunction

  function automatic int pick_wait(bit calm);
    return calm ? 0 : int'($urandom_range(0, 13));
  endfunction

  // Drive one pixel; the answer is queued at the transfer edge
  task automatic send_pixel(logic [hsv_pkg::HUE_W-1:0] hue, logic [hsv_pkg::SAT_W-1:0] sat,
                            logic [hsv_pkg::SAT_W-1:0] bri, rgb_t want);
    int gap;
    gap = pick_wait(in_calm);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid         <= 1'b1;
    in_bus.hue_in        <= hue;
    in_bus.saturation_in <= sat;
    in_bus.brightness_in <= bri;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    expected_rgb.push_back(want);
  endtask

  // Stimulus
  initial begin
    logic [hsv_pkg::HUE_W-1:0] hue;
    logic [hsv_pkg::SAT_W-1:0] sat;
    logic [hsv_pkg::SAT_W-1:0] bri;
    rgb_t want;
    int kind;

    in_bus.valid         = 1'b0;
    in_bus.hue_in        = '0;
    in_bus.saturation_in = '0;
    in_bus.brightness_in = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (pixel_rows[i]) begin
      if (pixel_rows[i].known_rgb)
        want = '{pixel_rows[i].red, pixel_rows[i].green, pixel_rows[i].blue};
      else
        want = predict_rgb(pixel_rows[i].hue, pixel_rows[i].sat, pixel_rows[i].bri);
      send_pixel(pixel_rows[i].hue, pixel_rows[i].sat, pixel_rows[i].bri, want);
    end

    // random pixels, mostly in range, some at sector edges and past the circle
    for (int n = 0; n < RANDOM_PIXELS; n++) begin
      if (n % 64 == 0) in_calm = ($urandom_range(0, 3) == 0);
      kind = int'($urandom_range(0, 9));
      case (kind)
        0: hue = hsv_pkg::HUE_W'($urandom_range(0, 65535));
        1: hue = hsv_pkg::HUE_W'(hsv_pkg::FULL_TURN);
        2: hue = hsv_pkg::HUE_W'($urandom_range(0, 6) * hsv_pkg::SECTOR_SIZE
                                 + $urandom_range(0, 2) - 1);
        default: hue = hsv_pkg::HUE_W'($urandom_range(0, hsv_pkg::FULL_TURN - 1));
      endcase
      kind = int'($urandom_range(0, 15));
      case (kind)
        0: sat = '0;
        1: sat = 9'd256;
        2: sat = hsv_pkg::SAT_W'($urandom_range(257, 511));
        default: sat = hsv_pkg::SAT_W'($urandom_range(0, 256));
      endcase
      kind = int'($urandom_range(0, 15));
      case (kind)
        0: bri = '0;
        1: bri = 9'd256;
        2: bri = hsv_pkg::SAT_W'($urandom_range(257, 511));
        default: bri = hsv_pkg::SAT_W'($urandom_range(0, 256));
      endcase
      send_pixel(hue, sat, bri, predict_rgb(hue, sat, bri));
    end
    in_bus.valid <= 1'b0;

    // drain
    while (expected_rgb.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // Result side: random backpressure and field checks
  always @(posedge clk) begin
    rgb_t want;
    int stall;
    static int stall_left = 0;
    static int results_seen = 0;
    if (!rst_n) begin
      sink_ready <= 1'b1;
      stall_left = 0;
    end else if (out_bus.valid && sink_ready) begin
      if (expected_rgb.size() == 0) begin
        $error("result with no pixel pending: r=%0d g=%0d b=%0d",
               out_bus.red_out, out_bus.green_out, out_bus.blue_out);
        fail_count++;
      end else begin
        want = expected_rgb.pop_front();
        if (out_bus.red_out !== want.red) begin
          $error("red_out: expected %0d, actual %0d", want.red, out_bus.red_out);
          fail_count++;
        end
        if (out_bus.green_out !== want.green) begin
          $error("green_out: expected %0d, actual %0d", want.green, out_bus.green_out);
          fail_count++;
        end
        if (out_bus.blue_out !== want.blue) begin
          $error("blue_out: expected %0d, actual %0d", want.blue, out_bus.blue_out);
          fail_count++;
        end
      end
      results_seen++;
      if (results_seen % 48 == 0) out_calm = ($urandom_range(0, 3) == 0);
      stall = pick_wait(out_calm);
      if (stall > 0) begin
        sink_ready <= 1'b0;
        stall_left = stall;
      end
    end else if (stall_left > 0) begin
      stall_left--;
      if (stall_left == 0) sink_ready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

endmodule
